// File: rtl/omp_pkg.sv
// Shared types and constants for the offline mail packet parser.
// No dependencies; imported by omp_parse, omp_out_reg and the top level.
package omp_pkg;

    typedef enum logic [1:0] {
        KIND_CHAR     = 2'd0,
        KIND_MSG_DONE = 2'd1,
        KIND_PKT_DONE = 2'd2,
        KIND_PKT_ERR  = 2'd3
    } result_kind_t;

    typedef enum logic [1:0] {
        FIELD_TO      = 2'd0,
        FIELD_FROM    = 2'd1,
        FIELD_SUBJECT = 2'd2,
        FIELD_BODY    = 2'd3
    } text_field_t;

    // Offsets within a 128-byte block
    localparam logic [6:0] BLOCK_LAST     = 7'd127;
    localparam logic [6:0] HDR_TEXT_START = 7'd21;
    localparam logic [6:0] HDR_FROM_START = 7'd46;
    localparam logic [6:0] HDR_SUBJ_START = 7'd71;
    localparam logic [6:0] HDR_TEXT_END   = 7'd96;
    localparam logic [6:0] NUM_START      = 7'd1;
    localparam logic [6:0] NUM_END        = 7'd8;
    localparam logic [6:0] CNT_START      = 7'd116;
    localparam logic [6:0] CNT_END        = 7'd122;
    localparam logic [6:0] CONF_LO        = 7'd123;
    localparam logic [6:0] CONF_HI        = 7'd124;

    localparam logic [7:0] EOL_MARK   = 8'hE3;
    localparam logic [7:0] SUB_CHAR   = 8'h1A;
    localparam logic [7:0] CHAR_LF    = 8'h0A;
    localparam logic [7:0] CHAR_SPACE = 8'h20;
    localparam logic [7:0] CHAR_NUL   = 8'h00;
    localparam logic [7:0] CHAR_ZERO  = 8'h30;
    localparam logic [7:0] CHAR_NINE  = 8'h39;

    localparam logic [23:0] COUNT_MAX = 24'hFFFFFF;

    typedef struct packed {
        result_kind_t kind;
        logic [7:0]   char_value;
        text_field_t  text_field;
        logic [12:0]  char_position;
        logic [23:0]  message_number;
        logic [15:0]  conference;
        logic [12:0]  body_length;
        logic [4:0]   to_length;
        logic [4:0]   from_length;
        logic [4:0]   subject_length;
        logic [23:0]  message_count;
    } result_t;

endpackage

// File: rtl/omp_parse.sv
// Packet parse state and next-state logic: one byte per accepted word.
// Depends on omp_pkg; produces a result_t and an emit strobe for each word that yields a result.
module omp_parse #(
    parameter int BODY_CAPACITY = 8192
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            take,
    input  logic [7:0]      byte_value,
    input  logic            end_of_input,
    output logic            emit,
    output omp_pkg::result_t res
);
    import omp_pkg::*;

    localparam int PosW = $clog2(BODY_CAPACITY);
    localparam logic [PosW-1:0] POS_LIMIT = PosW'(BODY_CAPACITY - 1);

    typedef enum logic [1:0] {
        PH_SKIP   = 2'd0,
        PH_HEADER = 2'd1,
        PH_TEXT   = 2'd2
    } phase_t;

    phase_t          phase_reg, phase_next;
    logic [6:0]      offset_reg, offset_next;
    logic [19:0]     blocks_left_reg, blocks_left_next;
    logic [19:0]     count_acc_reg, count_acc_next;
    logic [23:0]     number_acc_reg, number_acc_next;
    logic            num_stop_reg, num_stop_next;
    logic            cnt_stop_reg, cnt_stop_next;
    logic [15:0]     conf_reg, conf_next;
    logic [PosW-1:0] body_pos_reg, body_pos_next;
    logic [PosW-1:0] body_kept_reg, body_kept_next;
    logic [4:0]      to_len_reg, to_len_next;
    logic [4:0]      from_len_reg, from_len_next;
    logic [4:0]      subj_len_reg, subj_len_next;
    logic [23:0]     msg_seen_reg, msg_seen_next;
    logic            error_reg, error_next;

    logic        is_digit;
    logic [3:0]  digit;
    text_field_t hdr_field;
    logic [4:0]  hdr_pos;
    logic [7:0]  body_char;
    logic        stored;
    logic [19:0] blocks_dec;

    assign is_digit  = (byte_value >= CHAR_ZERO) && (byte_value <= CHAR_NINE);
    assign digit     = byte_value[3:0];
    assign body_char = (byte_value == EOL_MARK) ? CHAR_LF : byte_value;
    assign stored    = body_pos_reg < POS_LIMIT;
    assign blocks_dec = blocks_left_reg - 20'd1;

    // Split the header text window into To, From and Subject
    always_comb
    begin
        if (offset_reg < HDR_FROM_START)
        begin
            hdr_field = FIELD_TO;
            hdr_pos   = 5'(offset_reg - HDR_TEXT_START);
        end
        else if (offset_reg < HDR_SUBJ_START)
        begin
            hdr_field = FIELD_FROM;
            hdr_pos   = 5'(offset_reg - HDR_FROM_START);
        end
        else
        begin
            hdr_field = FIELD_SUBJECT;
            hdr_pos   = 5'(offset_reg - HDR_SUBJ_START);
        end
    end

    always_comb
    begin
        phase_next       = phase_reg;
        offset_next      = offset_reg;
        blocks_left_next = blocks_left_reg;
        count_acc_next   = count_acc_reg;
        number_acc_next  = number_acc_reg;
        num_stop_next    = num_stop_reg;
        cnt_stop_next    = cnt_stop_reg;
        conf_next        = conf_reg;
        body_pos_next    = body_pos_reg;
        body_kept_next   = body_kept_reg;
        to_len_next      = to_len_reg;
        from_len_next    = from_len_reg;
        subj_len_next    = subj_len_reg;
        msg_seen_next    = msg_seen_reg;
        error_next       = error_reg;
        emit             = 1'b0;
        res              = '0;

        if (end_of_input)
        begin
            emit = 1'b1;
            if (error_reg || (phase_reg != PH_HEADER) || (offset_reg != 7'd0))
            begin
                res.kind = KIND_PKT_ERR;
            end
            else
            begin
                res.kind          = KIND_PKT_DONE;
                res.message_count = msg_seen_reg;
            end
            // return to the reset state
            phase_next       = PH_SKIP;
            offset_next      = '0;
            blocks_left_next = '0;
            count_acc_next   = '0;
            number_acc_next  = '0;
            num_stop_next    = 1'b0;
            cnt_stop_next    = 1'b0;
            conf_next        = '0;
            body_pos_next    = '0;
            body_kept_next   = '0;
            to_len_next      = '0;
            from_len_next    = '0;
            subj_len_next    = '0;
            msg_seen_next    = '0;
            error_next       = 1'b0;
        end
        else if (!error_reg)
        begin
            unique case (phase_reg)
                PH_HEADER:
                begin
                    if (offset_reg == 7'd0)
                    begin
                        count_acc_next  = '0;
                        number_acc_next = '0;
                        num_stop_next   = 1'b0;
                        cnt_stop_next   = 1'b0;
                        conf_next       = '0;
                        to_len_next     = '0;
                        from_len_next   = '0;
                        subj_len_next   = '0;
                    end
                    if ((offset_reg >= NUM_START) && (offset_reg < NUM_END) && !num_stop_reg)
                    begin
                        if (is_digit)
                            number_acc_next = (number_acc_reg << 3) + (number_acc_reg << 1)
                                              + 24'(digit);
                        else if (byte_value != CHAR_SPACE)
                            num_stop_next = 1'b1;
                    end
                    if ((offset_reg >= CNT_START) && (offset_reg < CNT_END) && !cnt_stop_reg)
                    begin
                        if (is_digit)
                            count_acc_next = (count_acc_reg << 3) + (count_acc_reg << 1)
                                             + 20'(digit);
                        else if (byte_value != CHAR_SPACE)
                            cnt_stop_next = 1'b1;
                    end
                    if (offset_reg == CONF_LO)
                        conf_next[7:0] = byte_value;
                    if (offset_reg == CONF_HI)
                        conf_next[15:8] = byte_value;

                    if (offset_reg == BLOCK_LAST)
                    begin
                        offset_next    = '0;
                        body_pos_next  = '0;
                        body_kept_next = '0;
                        if (count_acc_reg == 20'd0)
                        begin
                            error_next = 1'b1;
                        end
                        else if (count_acc_reg == 20'd1)
                        begin
                            emit = 1'b1;
                            if (msg_seen_reg != COUNT_MAX)
                                msg_seen_next = msg_seen_reg + 24'd1;
                            res.kind           = KIND_MSG_DONE;
                            res.message_number = number_acc_reg;
                            res.conference     = conf_reg;
                            res.to_length      = to_len_reg;
                            res.from_length    = from_len_reg;
                            res.subject_length = subj_len_reg;
                        end
                        else
                        begin
                            blocks_left_next = count_acc_reg - 20'd1;
                            phase_next       = PH_TEXT;
                        end
                    end
                    else
                    begin
                        offset_next = offset_reg + 7'd1;
                        if ((offset_reg >= HDR_TEXT_START) && (offset_reg < HDR_TEXT_END))
                        begin
                            emit               = 1'b1;
                            res.kind           = KIND_CHAR;
                            res.char_value     = byte_value;
                            res.text_field     = hdr_field;
                            res.char_position  = 13'(hdr_pos);
                            if ((byte_value != CHAR_SPACE) && (byte_value != CHAR_NUL))
                            begin
                                unique case (hdr_field)
                                    FIELD_TO:      to_len_next   = hdr_pos + 5'd1;
                                    FIELD_FROM:    from_len_next = hdr_pos + 5'd1;
                                    FIELD_SUBJECT: subj_len_next = hdr_pos + 5'd1;
                                    default:       subj_len_next = subj_len_reg;
                                endcase
                            end
                        end
                    end
                end

                PH_TEXT:
                begin
                    if (stored)
                    begin
                        if ((body_char != CHAR_SPACE) && (body_char != SUB_CHAR) &&
                            (body_char != CHAR_LF) && (body_char != CHAR_NUL))
                            body_kept_next = body_pos_reg + PosW'(1);
                        body_pos_next = body_pos_reg + PosW'(1);
                        emit              = 1'b1;
                        res.kind          = KIND_CHAR;
                        res.char_value    = body_char;
                        res.text_field    = FIELD_BODY;
                        res.char_position = 13'(body_pos_reg);
                    end
                    if (offset_reg == BLOCK_LAST)
                    begin
                        offset_next      = '0;
                        blocks_left_next = blocks_dec;
                        if (blocks_dec == 20'd0)
                        begin
                            // last byte of the message: fold it into message done
                            phase_next = PH_HEADER;
                            emit       = 1'b1;
                            if (msg_seen_reg != COUNT_MAX)
                                msg_seen_next = msg_seen_reg + 24'd1;
                            res.kind           = KIND_MSG_DONE;
                            res.message_number = number_acc_reg;
                            res.conference     = conf_reg;
                            res.body_length    = 13'(body_kept_next);
                            res.to_length      = to_len_reg;
                            res.from_length    = from_len_reg;
                            res.subject_length = subj_len_reg;
                        end
                    end
                    else
                    begin
                        offset_next = offset_reg + 7'd1;
                    end
                end

                default:
                begin
                    if (offset_reg == BLOCK_LAST)
                    begin
                        offset_next = '0;
                        phase_next  = PH_HEADER;
                    end
                    else
                    begin
                        offset_next = offset_reg + 7'd1;
                    end
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg       <= PH_SKIP;
            offset_reg      <= '0;
            blocks_left_reg <= '0;
            count_acc_reg   <= '0;
            number_acc_reg  <= '0;
            num_stop_reg    <= 1'b0;
            cnt_stop_reg    <= 1'b0;
            conf_reg        <= '0;
            body_pos_reg    <= '0;
            body_kept_reg   <= '0;
            to_len_reg      <= '0;
            from_len_reg    <= '0;
            subj_len_reg    <= '0;
            msg_seen_reg    <= '0;
            error_reg       <= 1'b0;
        end
        else if (take)
        begin
            phase_reg       <= phase_next;
            offset_reg      <= offset_next;
            blocks_left_reg <= blocks_left_next;
            count_acc_reg   <= count_acc_next;
            number_acc_reg  <= number_acc_next;
            num_stop_reg    <= num_stop_next;
            cnt_stop_reg    <= cnt_stop_next;
            conf_reg        <= conf_next;
            body_pos_reg    <= body_pos_next;
            body_kept_reg   <= body_kept_next;
            to_len_reg      <= to_len_next;
            from_len_reg    <= from_len_next;
            subj_len_reg    <= subj_len_next;
            msg_seen_reg    <= msg_seen_next;
            error_reg       <= error_next;
        end
    end

endmodule

// File: rtl/omp_out_reg.sv
// Result register with valid/ready handshake toward the consumer.
// Depends on omp_pkg for result_t.
module omp_out_reg (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             load,
    input  omp_pkg::result_t din,
    input  logic             result_ready,
    output logic             result_valid,
    output logic             free,
    output omp_pkg::result_t dout
);
    import omp_pkg::*;

    logic    valid_reg, valid_next;
    result_t data_reg;

    // free when empty or the held word leaves this cycle
    assign free = !valid_reg || result_ready;

    always_comb
    begin
        valid_next = valid_reg;
        if (load)
            valid_next = 1'b1;
        else if (result_ready)
            valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (load)
            data_reg <= din;
    end

    assign result_valid = valid_reg;
    assign dout         = data_reg;

endmodule

// File: rtl/offline_mail_packet_parser.sv
// Top level of the offline mail packet parser (128-byte block message packets).
// Depends on omp_pkg, omp_parse and omp_out_reg.
//
//   channel   handshake                   payload
//   input     byte_valid / byte_ready     byte_value, end_of_input
//   result    result_valid / result_ready result_kind ... message_count
//
// One byte per cycle: the parse state updates at the accepting edge and the
// result, if any, lands in the result register at that same edge, so it is
// visible in the cycle after the byte. Reset clears all parse state and the
// result valid flag. Input stalls only while a held result is not taken.
module offline_mail_packet_parser #(
    parameter int BODY_CAPACITY = 8192
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        byte_valid,
    output logic        byte_ready,
    input  logic [7:0]  byte_value,
    input  logic        end_of_input,
    output logic        result_valid,
    input  logic        result_ready,
    output logic [1:0]  result_kind,
    output logic [7:0]  char_value,
    output logic [1:0]  text_field,
    output logic [12:0] char_position,
    output logic [23:0] message_number,
    output logic [15:0] conference,
    output logic [12:0] body_length,
    output logic [4:0]  to_length,
    output logic [4:0]  from_length,
    output logic [4:0]  subject_length,
    output logic [23:0] message_count
);
    import omp_pkg::*;

    logic    take;
    logic    emit;
    logic    free;
    result_t res;
    result_t held;

    assign byte_ready = free;
    assign take       = byte_valid && free;

    omp_parse #(
        .BODY_CAPACITY(BODY_CAPACITY)
    ) u_parse (
        .clk          (clk),
        .rst_n        (rst_n),
        .take         (take),
        .byte_value   (byte_value),
        .end_of_input (end_of_input),
        .emit         (emit),
        .res          (res)
    );

    omp_out_reg u_out (
        .clk          (clk),
        .rst_n        (rst_n),
        .load         (take && emit),
        .din          (res),
        .result_ready (result_ready),
        .result_valid (result_valid),
        .free         (free),
        .dout         (held)
    );

    assign result_kind    = held.kind;
    assign char_value     = held.char_value;
    assign text_field     = held.text_field;
    assign char_position  = held.char_position;
    assign message_number = held.message_number;
    assign conference     = held.conference;
    assign body_length    = held.body_length;
    assign to_length      = held.to_length;
    assign from_length    = held.from_length;
    assign subject_length = held.subject_length;
    assign message_count  = held.message_count;

endmodule

// File: test/offline_mail_packet_parser_tb.sv
// Self-checking testbench for offline_mail_packet_parser: streams packet bytes through the
// valid/ready input, stalls both channels at random, and checks each result word in order.
// Depends on omp_pkg and the RTL top level offline_mail_packet_parser.
module offline_mail_packet_parser_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import omp_pkg::*;

    localparam int BODY_CAPACITY = 8192;
    localparam int BLOCK_BYTES   = 128;
    localparam int HDR_FIELD_LEN = 25;
    localparam int CYCLE_LIMIT   = 4_000_000;
    localparam int RANDOM_WORDS  = 400;

    // digit parse stop bits
    localparam int STOP_NUMBER = 0;
    localparam int STOP_COUNT  = 1;

    // layouts of an ASCII decimal header field
    localparam int DEC_LEFT       = 0;
    localparam int DEC_RIGHT      = 1;
    localparam int DEC_ZERO_FILL  = 2;
    localparam int DEC_STOPPER    = 3;
    localparam int DEC_SPLIT      = 4;
    localparam int DEC_BLANK      = 5;
    localparam int DEC_STOP_FIRST = 6;

    // contents of the To/From/Subject fields
    localparam int TXT_TYPICAL = 0;
    localparam int TXT_FULL    = 1;
    localparam int TXT_EMPTY   = 2;
    localparam int TXT_RAW     = 3;

    typedef enum logic [1:0] {
        PH_SKIP   = 2'd0,
        PH_HEADER = 2'd1,
        PH_TEXT   = 2'd2
    } parse_phase_t;

    logic        clk = 1'b0;
    logic        rst_n;
    logic        byte_valid;
    logic        byte_ready;
    logic [7:0]  byte_value;
    logic        end_of_input;
    logic        result_valid;
    logic        result_ready;
    logic [1:0]  result_kind;
    logic [7:0]  char_value;
    logic [1:0]  text_field;
    logic [12:0] char_position;
    logic [23:0] message_number;
    logic [15:0] conference;
    logic [12:0] body_length;
    logic [4:0]  to_length;
    logic [4:0]  from_length;
    logic [4:0]  subject_length;
    logic [23:0] message_count;

    offline_mail_packet_parser #(.BODY_CAPACITY(BODY_CAPACITY)) uut (.*);

    always #6 clk = ~clk;

    // parser state as the bench sees it
    parse_phase_t pred_phase;
    logic [6:0]   pred_offset;
    logic [19:0]  blocks_remaining;
    logic [19:0]  count_digits;
    logic [23:0]  number_digits;
    logic [1:0]   digit_stop;
    logic [15:0]  conf_bytes;
    logic [12:0]  body_fill;
    logic [12:0]  body_trim_len;
    logic [4:0]   hdr_trim_len [3];
    logic [23:0]  msg_total;
    logic         error_seen;

    result_t     expected_results [$];
    logic [7:0]  hdr_buf [BLOCK_BYTES];
    int          mismatch_count;
    int          cycle_count;
    int          items_sent;
    int          ignored_words;
    int          ready_hold;
    bit          steady_flow;

    function automatic void clear_prediction();
        pred_phase       = PH_SKIP;
        pred_offset      = '0;
        blocks_remaining = '0;
        count_digits     = '0;
        number_digits    = '0;
        digit_stop       = '0;
        conf_bytes       = '0;
        body_fill        = '0;
        body_trim_len    = '0;
        hdr_trim_len     = '{default: '0};
        msg_total        = '0;
        error_seen       = 1'b0;
    endfunction

    function automatic logic [23:0] accumulate_digit(logic [23:0] acc, logic [7:0] b, int idx);
        if (digit_stop[idx])
            return acc;
        if (b >= CHAR_ZERO && b <= CHAR_NINE)
            return acc * 24'd10 + 24'(b - CHAR_ZERO);
        if (b != CHAR_SPACE)
            digit_stop[idx] = 1'b1;
        return acc;
    endfunction

    function automatic void close_message(logic [7:0] ch, text_field_t fld, logic [12:0] pos);
        result_t r;
        if (msg_total < COUNT_MAX)
            msg_total = msg_total + 24'd1;
        r = '0;
        r.kind           = KIND_MSG_DONE;
        r.char_value     = ch;
        r.text_field     = fld;
        r.char_position  = pos;
        r.message_number = number_digits;
        r.conference     = conf_bytes;
        r.body_length    = body_trim_len;
        r.to_length      = hdr_trim_len[0];
        r.from_length    = hdr_trim_len[1];
        r.subject_length = hdr_trim_len[2];
        expected_results.push_back(r);
    endfunction

    // Advance the bench copy of the parser by one accepted word.
    function automatic void predict_word(logic [7:0] b, logic eoi);
        result_t     r;
        logic [6:0]  o;
        logic [7:0]  c;
        logic        stored;
        logic [12:0] pos;
        int          rel;
        bit          emit;
        r = '0;
        o = pred_offset;
        emit = 1'b0;
        if (eoi)
        begin
            if (error_seen || pred_phase != PH_HEADER || o != 7'd0)
                r.kind = KIND_PKT_ERR;
            else
            begin
                r.kind = KIND_PKT_DONE;
                r.message_count = msg_total;
            end
            expected_results.push_back(r);
            clear_prediction();
            return;
        end
        if (error_seen)
            return;
        case (pred_phase)
            PH_HEADER:
            begin
                if (o == 7'd0)
                begin
                    count_digits  = '0;
                    number_digits = '0;
                    digit_stop    = '0;
                    conf_bytes    = '0;
                    hdr_trim_len  = '{default: '0};
                end
                if (o >= NUM_START && o < NUM_END)
                    number_digits = accumulate_digit(number_digits, b, STOP_NUMBER);
                if (o >= CNT_START && o < CNT_END)
                    count_digits = 20'(accumulate_digit({4'd0, count_digits}, b, STOP_COUNT));
                if (o == CONF_LO)
                    conf_bytes[7:0] = b;
                if (o == CONF_HI)
                    conf_bytes[15:8] = b;
                if (o >= HDR_TEXT_START && o < HDR_TEXT_END)
                begin
                    rel = int'(o - HDR_TEXT_START);
                    if (b != CHAR_SPACE && b != CHAR_NUL)
                        hdr_trim_len[rel / HDR_FIELD_LEN] = 5'(rel % HDR_FIELD_LEN + 1);
                    r.kind          = KIND_CHAR;
                    r.char_value    = b;
                    r.text_field    = text_field_t'(rel / HDR_FIELD_LEN);
                    r.char_position = 13'(rel % HDR_FIELD_LEN);
                    emit = 1'b1;
                end
                if (o == BLOCK_LAST)
                begin
                    pred_offset   = '0;
                    body_fill     = '0;
                    body_trim_len = '0;
                    if (count_digits == 20'd0)
                        error_seen = 1'b1;
                    else if (count_digits == 20'd1)
                        close_message(CHAR_NUL, FIELD_TO, 13'd0);
                    else
                    begin
                        blocks_remaining = count_digits - 20'd1;
                        pred_phase = PH_TEXT;
                    end
                end
                else
                begin
                    pred_offset = o + 7'd1;
                    if (emit)
                        expected_results.push_back(r);
                end
            end
            PH_TEXT:
            begin
                c = (b == EOL_MARK) ? CHAR_LF : b;
                stored = (body_fill < 13'(BODY_CAPACITY - 1));
                pos = body_fill;
                if (stored)
                begin
                    if (c != CHAR_SPACE && c != SUB_CHAR && c != CHAR_LF && c != CHAR_NUL)
                        body_trim_len = body_fill + 13'd1;
                    body_fill = body_fill + 13'd1;
                end
                if (o == BLOCK_LAST)
                begin
                    pred_offset = '0;
                    blocks_remaining = blocks_remaining - 20'd1;
                    if (blocks_remaining == 20'd0)
                    begin
                        pred_phase = PH_HEADER;
                        if (stored)
                            close_message(c, FIELD_BODY, pos);
                        else
                            close_message(CHAR_NUL, FIELD_TO, 13'd0);
                        return;
                    end
                end
                else
                    pred_offset = o + 7'd1;
                if (stored)
                begin
                    r.kind          = KIND_CHAR;
                    r.char_value    = c;
                    r.text_field    = FIELD_BODY;
                    r.char_position = pos;
                    expected_results.push_back(r);
                end
            end
            default:
            begin
                // block 0 carries nothing of interest
                if (o >= BLOCK_LAST)
                begin
                    pred_offset = '0;
                    pred_phase = PH_HEADER;
                end
                else
                    pred_offset = o + 7'd1;
            end
        endcase
    endfunction

    task automatic report_mismatch(input string what);
        mismatch_count++;
        if (mismatch_count <= 40)
            $display("MISMATCH cycle %0d: %s", cycle_count, what);
    endtask

    task automatic check_field(input string name, input logic [31:0] got, input logic [31:0] want);
        if (got !== want)
            report_mismatch($sformatf("%s got %0h want %0h", name, got, want));
    endtask

    always @(posedge clk)
    begin : result_check
        result_t want;
        if (rst_n && result_valid && result_ready)
        begin
            if (expected_results.size() == 0)
                report_mismatch("result word with nothing expected");
            else
            begin
                want = expected_results.pop_front();
                check_field("result_kind", result_kind, want.kind);
                check_field("char_value", char_value, want.char_value);
                check_field("text_field", text_field, want.text_field);
                check_field("char_position", char_position, want.char_position);
                check_field("message_number", message_number, want.message_number);
                check_field("conference", conference, want.conference);
                check_field("body_length", body_length, want.body_length);
                check_field("to_length", to_length, want.to_length);
                check_field("from_length", from_length, want.from_length);
                check_field("subject_length", subject_length, want.subject_length);
                check_field("message_count", message_count, want.message_count);
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Regression FAIL");
            $finish;
        end
    end

    // result side back-pressure: mostly ready, short stalls, now and then a long one
    always @(negedge clk)
    begin : result_stall
        int roll;
        if (ready_hold > 0)
        begin
            result_ready = 1'b0;
            ready_hold--;
        end
        else if (steady_flow)
            result_ready = 1'b1;
        else
        begin
            roll = $urandom_range(0, 99);
            if (roll < 70)
                result_ready = 1'b1;
            else if (roll < 97)
            begin
                result_ready = 1'b0;
                ready_hold = $urandom_range(0, 2);
            end
            else
            begin
                result_ready = 1'b0;
                ready_hold = $urandom_range(10, 40);
            end
        end
    end

    function automatic int pick_gap();
        int roll;
        if (steady_flow)
            return 0;
        roll = $urandom_range(0, 99);
        if (roll < 75)
            return 0;
        if (roll < 97)
            return $urandom_range(1, 3);
        return $urandom_range(10, 30);
    endfunction

    // Call at a falling edge; returns at a falling edge after the word is taken.
    task automatic send_byte(input logic [7:0] b, input logic eoi);
        int gap;
        byte_value   = b;
        end_of_input = eoi;
        byte_valid   = 1'b1;
        @(posedge clk);
        while (!byte_ready)
            @(posedge clk);
        predict_word(b, eoi);
        items_sent++;
        @(negedge clk);
        gap = pick_gap();
        if (gap > 0)
        begin
            byte_valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
    endtask

    // Hold the sender until every expected word is back.
    task automatic drain_results();
        byte_valid = 1'b0;
        while (expected_results.size() != 0)
            @(negedge clk);
    endtask

    task automatic send_filler(input int n, input bit ignored);
        int i;
        for (i = 0; i < n; i++)
            send_byte(8'($urandom), 1'b0);
        if (ignored)
            ignored_words += n;
    endtask

    function automatic logic [7:0] pick_stopper();
        logic [7:0] x;
        do
            x = 8'($urandom);
        while ((x >= CHAR_ZERO && x <= CHAR_NINE) || x == CHAR_SPACE);
        return x;
    endfunction

    function automatic logic [7:0] pick_digit();
        return 8'($urandom_range(CHAR_ZERO, CHAR_NINE));
    endfunction

    function automatic void put_decimal(int start, int len, int value, int style);
        string s;
        int    n;
        int    k;
        s = $sformatf("%0d", value);
        n = s.len();
        if ((style == DEC_STOPPER || style == DEC_SPLIT) && n + 1 > len)
            style = DEC_LEFT;
        for (k = 0; k < len; k++)
            hdr_buf[start + k] = CHAR_SPACE;
        case (style)
            DEC_RIGHT:
                for (k = 0; k < n; k++)
                    hdr_buf[start + len - n + k] = s[k];
            DEC_ZERO_FILL:
                for (k = 0; k < len; k++)
                begin
                    if (k < len - n)
                        hdr_buf[start + k] = CHAR_ZERO;
                    else
                        hdr_buf[start + k] = s[k - (len - n)];
                end
            DEC_STOPPER:
            begin
                for (k = 0; k < n; k++)
                    hdr_buf[start + k] = s[k];
                hdr_buf[start + n] = pick_stopper();
                for (k = n + 1; k < len; k++)
                    hdr_buf[start + k] = pick_digit();
            end
            DEC_SPLIT:
            begin
                // a space inside the digits is skipped by the parse
                hdr_buf[start] = s[0];
                for (k = 1; k < n; k++)
                    hdr_buf[start + k + 1] = s[k];
            end
            DEC_BLANK:
                ;
            DEC_STOP_FIRST:
            begin
                hdr_buf[start] = pick_stopper();
                for (k = 1; k < len; k++)
                    hdr_buf[start + k] = pick_digit();
            end
            default:
                for (k = 0; k < n; k++)
                    hdr_buf[start + k] = s[k];
        endcase
    endfunction

    function automatic void build_header(int number, int num_style, int count, int cnt_style,
                                         logic [15:0] conf, int txt_style);
        int i;
        int f;
        int p;
        int fill;
        int idx;
        for (i = 0; i < BLOCK_BYTES; i++)
            hdr_buf[i] = 8'($urandom);
        put_decimal(NUM_START, NUM_END - NUM_START, number, num_style);
        put_decimal(CNT_START, CNT_END - CNT_START, count, cnt_style);
        hdr_buf[CONF_LO] = conf[7:0];
        hdr_buf[CONF_HI] = conf[15:8];
        for (f = 0; f < 3; f++)
        begin
            case (txt_style)
                TXT_FULL:  fill = HDR_FIELD_LEN;
                TXT_EMPTY: fill = 0;
                default:   fill = $urandom_range(0, HDR_FIELD_LEN);
            endcase
            for (p = 0; p < HDR_FIELD_LEN; p++)
            begin
                idx = HDR_TEXT_START + f * HDR_FIELD_LEN + p;
                if (txt_style == TXT_RAW)
                    hdr_buf[idx] = 8'($urandom);
                else if (p < fill)
                    hdr_buf[idx] = (txt_style == TXT_TYPICAL && $urandom_range(0, 7) == 0) ?
                                   8'($urandom) : 8'($urandom_range(8'h21, 8'h7E));
                else
                    hdr_buf[idx] = $urandom_range(0, 1) ? CHAR_SPACE : CHAR_NUL;
            end
        end
    endfunction

    task automatic send_header(input int n);
        int i;
        for (i = 0; i < n; i++)
            send_byte(hdr_buf[i], 1'b0);
    endtask

    function automatic logic [7:0] pad_byte();
        case ($urandom_range(0, 4))
            0:       return CHAR_SPACE;
            1:       return SUB_CHAR;
            2:       return CHAR_NUL;
            3:       return EOL_MARK;
            default: return CHAR_LF;
        endcase
    endfunction

    // Send text blocks; stop early after limit words when limit is not negative.
    task automatic send_body(input int blocks, input int limit);
        int total;
        int tail_from;
        int i;
        total = blocks * BLOCK_BYTES;
        tail_from = total;
        if (blocks > 0 && $urandom_range(0, 1))
            tail_from = total - $urandom_range(1, BLOCK_BYTES);
        if (limit >= 0 && limit < total)
            total = limit;
        for (i = 0; i < total; i++)
        begin
            if (i >= tail_from || $urandom_range(0, 7) == 0)
                send_byte(pad_byte(), 1'b0);
            else
                send_byte(8'($urandom), 1'b0);
        end
    endtask

    task automatic send_message(input int count, input int cnt_style);
        build_header($urandom_range(0, 9999999), $urandom_range(DEC_LEFT, DEC_STOP_FIRST),
                     count, cnt_style, 16'($urandom), $urandom_range(TXT_TYPICAL, TXT_RAW));
        send_header(BLOCK_BYTES);
        send_body(count - 1, -1);
    endtask

    function automatic int pick_zero_style();
        case ($urandom_range(0, 3))
            0:       return DEC_LEFT;
            1:       return DEC_ZERO_FILL;
            2:       return DEC_BLANK;
            default: return DEC_STOP_FIRST;
        endcase
    endfunction

    task automatic send_broken_message();
        int count;
        int limit;
        case ($urandom_range(0, 2))
            0:
            begin
                // zero block count: everything after the header is dropped
                build_header($urandom_range(0, 9999999), DEC_RIGHT, 0, pick_zero_style(),
                             16'($urandom), TXT_TYPICAL);
                send_header(BLOCK_BYTES);
                send_filler($urandom_range(0, 300), 1'b1);
            end
            1:
            begin
                build_header($urandom_range(0, 9999999), DEC_LEFT, 2, DEC_LEFT,
                             16'($urandom), TXT_TYPICAL);
                send_header($urandom_range(1, BLOCK_BYTES - 1));
            end
            default:
            begin
                count = ($urandom_range(0, 3) == 0) ? 999999 : $urandom_range(2, 4);
                limit = (count - 1) * BLOCK_BYTES;
                if (limit > 400)
                    limit = 400;
                build_header($urandom_range(0, 9999999), DEC_LEFT, count, DEC_RIGHT,
                             16'($urandom), TXT_TYPICAL);
                send_header(BLOCK_BYTES);
                send_body(count - 1, $urandom_range(0, limit - 1));
            end
        endcase
    endtask

    task automatic test_packet_boundaries();
        send_byte(8'hFF, 1'b1);
        send_byte(8'h00, 1'b1);
        send_filler(5, 1'b0);
        send_byte(8'($urandom), 1'b1);
        send_filler(BLOCK_BYTES, 1'b0);
        send_byte(8'($urandom), 1'b1);
        drain_results();
    endtask

    task automatic test_single_block_messages();
        send_filler(BLOCK_BYTES, 1'b0);
        build_header(9999999, DEC_RIGHT, 1, DEC_LEFT, 16'hFFFF, TXT_FULL);
        send_header(BLOCK_BYTES);
        build_header(0, DEC_BLANK, 1, DEC_ZERO_FILL, 16'h0000, TXT_EMPTY);
        send_header(BLOCK_BYTES);
        build_header(4321, DEC_STOPPER, 1, DEC_SPLIT, 16'h8001, TXT_RAW);
        send_header(BLOCK_BYTES);
        build_header(77, DEC_STOP_FIRST, 1, DEC_RIGHT, 16'($urandom), TXT_TYPICAL);
        send_header(BLOCK_BYTES);
        send_byte(8'h00, 1'b1);
        drain_results();
    endtask

    task automatic test_text_messages();
        send_filler(BLOCK_BYTES, 1'b0);
        send_message(2, DEC_LEFT);
        drain_results();
        send_message(3, DEC_STOPPER);
        steady_flow = 1'b1;
        send_message(6, DEC_SPLIT);
        steady_flow = 1'b0;
        send_byte(8'hFF, 1'b1);
        drain_results();
    endtask

    task automatic test_zero_count();
        send_filler(BLOCK_BYTES, 1'b0);
        build_header(12, DEC_LEFT, 0, DEC_STOP_FIRST, 16'h1234, TXT_TYPICAL);
        send_header(BLOCK_BYTES);
        send_filler(40, 1'b1);
        send_byte(8'($urandom), 1'b1);
        send_filler(BLOCK_BYTES, 1'b0);
        build_header(34, DEC_LEFT, 0, DEC_BLANK, 16'h0000, TXT_TYPICAL);
        send_header(BLOCK_BYTES);
        send_byte(8'($urandom), 1'b1);
        send_filler(BLOCK_BYTES, 1'b0);
        send_message(2, DEC_RIGHT);
        build_header(56, DEC_LEFT, 0, DEC_LEFT, 16'hFFFF, TXT_TYPICAL);
        send_header(BLOCK_BYTES);
        send_byte(8'($urandom), 1'b1);
        drain_results();
    endtask

    task automatic test_truncated_streams();
        send_filler(BLOCK_BYTES, 1'b0);
        build_header(1, DEC_LEFT, 3, DEC_LEFT, 16'h0001, TXT_TYPICAL);
        send_header(BLOCK_BYTES);
        send_body(2, BLOCK_BYTES);
        send_byte(8'($urandom), 1'b1);
        send_filler(BLOCK_BYTES, 1'b0);
        build_header(2, DEC_LEFT, 2, DEC_LEFT, 16'h0002, TXT_TYPICAL);
        send_header(60);
        send_byte(8'($urandom), 1'b1);
        send_filler(BLOCK_BYTES, 1'b0);
        build_header(3, DEC_LEFT, 999999, DEC_LEFT, 16'h0003, TXT_TYPICAL);
        send_header(BLOCK_BYTES);
        send_body(999998, 200);
        send_byte(8'($urandom), 1'b1);
        send_filler(BLOCK_BYTES, 1'b0);
        send_message(1, DEC_LEFT);
        build_header(4, DEC_LEFT, 2, DEC_ZERO_FILL, 16'h0004, TXT_TYPICAL);
        send_header(BLOCK_BYTES);
        send_body(1, 77);
        send_byte(8'($urandom), 1'b1);
        drain_results();
    endtask

    task automatic test_random_packets();
        int start;
        int roll;
        int n_msgs;
        int m;
        start = items_sent - ignored_words;
        while (items_sent - ignored_words - start < RANDOM_WORDS)
        begin
            roll = $urandom_range(0, 99);
            steady_flow = ($urandom_range(0, 4) == 0);
            if (roll < 6)
                send_filler($urandom_range(0, BLOCK_BYTES - 1), 1'b0);
            else
            begin
                send_filler(BLOCK_BYTES, 1'b0);
                n_msgs = $urandom_range(0, 3);
                for (m = 0; m < n_msgs; m++)
                begin
                    if (roll >= 85 && m == n_msgs - 1)
                        send_broken_message();
                    else if ($urandom_range(0, 9) == 0)
                        send_message($urandom_range(4, 6), $urandom_range(DEC_LEFT, DEC_SPLIT));
                    else
                        send_message($urandom_range(1, 3), $urandom_range(DEC_LEFT, DEC_SPLIT));
                end
            end
            send_byte(8'($urandom), 1'b1);
            if ($urandom_range(0, 3) == 0)
                drain_results();
        end
        steady_flow = 1'b0;
        drain_results();
    endtask

    initial
    begin
        rst_n          = 1'b0;
        byte_valid     = 1'b0;
        byte_value     = '0;
        end_of_input   = 1'b0;
        result_ready   = 1'b0;
        mismatch_count = 0;
        cycle_count    = 0;
        items_sent     = 0;
        ignored_words  = 0;
        ready_hold     = 0;
        steady_flow    = 1'b0;
        clear_prediction();
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_packet_boundaries();
        test_single_block_messages();
        test_text_messages();
        test_zero_count();
        test_truncated_streams();
        test_random_packets();

        repeat (20) @(posedge clk);
        if (expected_results.size() != 0)
            report_mismatch($sformatf("%0d expected words never came", expected_results.size()));
        if (mismatch_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

// File: files.f
rtl/omp_pkg.sv
rtl/omp_parse.sv
rtl/omp_out_reg.sv
rtl/offline_mail_packet_parser.sv
test/offline_mail_packet_parser_tb.sv
